// ----- src/sprite_animation_script_sequencer_unit_defines.svh -----
// Assertion macros shared by the sprite script sequencer RTL.
`ifndef SPRITE_ANIMATION_SCRIPT_SEQUENCER_UNIT_DEFINES_SVH
`define SPRITE_ANIMATION_SCRIPT_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SASU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SASU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sasu_pkg.sv -----
// Package with the types, character codes and helpers of the sprite script sequencer.
`timescale 1ns / 1ps

package sasu_pkg;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_BEGIN  = 2'd1;
    localparam logic [1:0] CMD_APPEND = 2'd2;

    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;

    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_DIGIT  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    typedef struct packed {
        logic       clr;
        logic       en;
        logic [3:0] digit;
    } t_acc_ctrl;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] res;
        res = c;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            res = c - CASE_OFFSET;
        end
        return res;
    endfunction

endpackage

// ----- src/sasu_store.sv -----
// Script character store: one write port and one registered read port.
`timescale 1ns / 1ps

module sasu_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sasu_digit_acc.sv -----
// Decimal accumulator: value times ten plus one digit, saturating at the all-ones value.
`timescale 1ns / 1ps

module sasu_digit_acc #(
    parameter int NW = 16
) (
    input  logic                i_clk,
    input  sasu_pkg::t_acc_ctrl i_ctrl,
    output logic [NW-1:0]       o_value
);

    import sasu_pkg::*;

    logic [NW-1:0] r_acc;
    logic [NW-1:0] n_acc;
    logic [NW+3:0] w_ext;
    logic [NW+3:0] w_sum;

    // Times ten as two shifts and an add; the result never needs more than four extra bits.
    assign w_ext = {4'b0000, r_acc};
    assign w_sum = (w_ext << 3) + (w_ext << 1) + {{NW{1'b0}}, i_ctrl.digit};

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clr) begin
            n_acc = '0;
        end else if (i_ctrl.en) begin
            n_acc = (w_sum[NW+3:NW] != 4'b0000) ? {NW{1'b1}} : w_sum[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_value = r_acc;

endmodule

// ----- src/sprite_animation_script_sequencer_unit.sv -----
// Top level of the sprite script sequencer: command sequencer, state registers and result stage.
// Steps: begin, append, unused codes and ticks that are idle or only count down the wait
// go from acceptance straight to the result state; H, S, B and skipped characters pass
// decode first; F and W pass decode, then the digit state through the digits, then result.
// One item at a time: no new item is taken until the result is loaded and idle returns.
// Synchronous active-low reset clears the script length, position, frame and wait and shows
// the sprite; the character store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

`include "sprite_animation_script_sequencer_unit_defines.svh"

module sprite_animation_script_sequencer_unit #(
    parameter int SCRIPT_DEPTH = 256,
    parameter int NUMBER_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input channel: an item is taken when i_valid is high and o_stall is low.
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_cmd,
    input  logic [7:0]              i_script_char,
    // Result channel: an item leaves when o_valid is high and i_stall is low.
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [NUMBER_WIDTH-1:0] o_frame_number,
    output logic                    o_is_visible,
    output logic                    o_script_running,
    output logic                    o_load_overflow
);

    import sasu_pkg::*;

    localparam int AW = (SCRIPT_DEPTH > 1) ? $clog2(SCRIPT_DEPTH) : 1;
    localparam int LW = $clog2(SCRIPT_DEPTH + 1);

    // Sequencer and script state.
    t_state                  r_state, n_state;
    logic [LW-1:0]           r_len, n_len;
    logic [LW-1:0]           r_pos, n_pos;
    logic [NUMBER_WIDTH-1:0] r_frame, n_frame;
    logic [NUMBER_WIDTH-1:0] r_wait, n_wait;
    logic                    r_vis, n_vis;
    logic                    r_ovf, n_ovf;
    logic                    r_tgt_wait, n_tgt_wait;

    // Result stage.
    logic                    r_out_valid, n_out_valid;
    logic [NUMBER_WIDTH-1:0] r_out_frame;
    logic                    r_out_vis;
    logic                    r_out_run;
    logic                    r_out_ovf;
    logic                    w_out_load;

    // Store and accumulator connections.
    logic                    w_we;
    logic [AW-1:0]           w_raddr;
    logic [7:0]              w_rd;
    logic [7:0]              w_wdata;
    logic [LW-1:0]           w_pos_inc;
    logic                    w_is_digit;
    logic                    w_in_acc;
    t_acc_ctrl               w_acc_ctrl;
    logic [NUMBER_WIDTH-1:0] w_acc_value;

    sasu_store #(
        .DEPTH (SCRIPT_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    sasu_digit_acc #(
        .NW (NUMBER_WIDTH)
    ) u_acc (
        .i_clk   (i_clk),
        .i_ctrl  (w_acc_ctrl),
        .o_value (w_acc_value)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_wdata    = to_upper(i_script_char);
    assign w_pos_inc  = r_pos + 1'b1;
    assign w_is_digit = (w_rd >= CH_0) && (w_rd <= CH_9);

    // The store is read every cycle. In the idle state the address is the read position, so
    // the character under it is waiting in the read register when a tick moves to decode.
    // During number parsing the address runs one ahead, so each cycle sees the next digit.
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_pos       = r_pos;
        n_frame     = r_frame;
        n_wait      = r_wait;
        n_vis       = r_vis;
        n_ovf       = r_ovf;
        n_tgt_wait  = r_tgt_wait;
        n_out_valid = r_out_valid && i_stall;
        w_out_load  = 1'b0;
        w_we        = 1'b0;
        w_raddr     = r_pos[AW-1:0];
        w_acc_ctrl  = '{clr: 1'b0, en: 1'b0, digit: w_rd[3:0]};

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_ovf   = 1'b0;
                    n_state = S_RESULT;
                    unique case (i_cmd)
                        CMD_TICK: begin
                            // An empty script does nothing; a pending wait only counts down.
                            if (r_len != '0) begin
                                if (r_wait != '0) begin
                                    n_wait = r_wait - 1'b1;
                                end else begin
                                    n_state = S_DECODE;
                                end
                            end
                        end
                        CMD_BEGIN: begin
                            n_len   = '0;
                            n_pos   = '0;
                            n_frame = '0;
                            n_wait  = '0;
                            n_vis   = 1'b1;
                        end
                        CMD_APPEND: begin
                            if (r_len == LW'(SCRIPT_DEPTH)) begin
                                n_ovf = 1'b1;
                            end else begin
                                w_we  = 1'b1;
                                n_len = r_len + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DECODE: begin
                n_state = S_RESULT;
                unique case (w_rd)
                    CH_F, CH_W: begin
                        n_pos           = w_pos_inc;
                        n_tgt_wait      = (w_rd == CH_W);
                        w_acc_ctrl.clr  = 1'b1;
                        w_raddr         = w_pos_inc[AW-1:0];
                        n_state         = S_DIGIT;
                    end
                    CH_H: begin
                        n_vis = 1'b0;
                        n_pos = w_pos_inc;
                    end
                    CH_S: begin
                        n_vis = 1'b1;
                        n_pos = w_pos_inc;
                    end
                    CH_B: begin
                        n_pos = '0;
                    end
                    default: begin
                        n_pos = w_pos_inc;
                    end
                endcase
                // Running off the end empties the script but keeps frame, wait and visibility.
                if (n_state == S_RESULT && n_pos >= r_len) begin
                    n_len = '0;
                    n_pos = '0;
                end
            end
            S_DIGIT: begin
                // A digit run never consumes the last character of the script.
                if (w_is_digit && w_pos_inc < r_len) begin
                    w_acc_ctrl.en = 1'b1;
                    n_pos         = w_pos_inc;
                    w_raddr       = w_pos_inc[AW-1:0];
                end else begin
                    if (r_tgt_wait) begin
                        n_wait = w_acc_value;
                    end else begin
                        n_frame = w_acc_value;
                    end
                    if (r_pos >= r_len) begin
                        n_len = '0;
                        n_pos = '0;
                    end
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // Hold until the result stage is empty or being emptied this cycle.
                if (!(r_out_valid && i_stall)) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_pos       <= '0;
            r_frame     <= '0;
            r_wait      <= '0;
            r_vis       <= 1'b1;
            r_ovf       <= 1'b0;
            r_tgt_wait  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_frame     <= n_frame;
            r_wait      <= n_wait;
            r_vis       <= n_vis;
            r_ovf       <= n_ovf;
            r_tgt_wait  <= n_tgt_wait;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_frame <= r_frame;
            r_out_vis   <= r_vis;
            r_out_run   <= (r_len != '0);
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_number   = r_out_frame;
    assign o_is_visible     = r_out_vis;
    assign o_script_running = r_out_run;
    assign o_load_overflow  = r_out_ovf;

    `SASU_ASSERT_NOW(a_len_in_range, 1'b1, r_len <= LW'(SCRIPT_DEPTH), "length past store depth")
    `SASU_ASSERT_NOW(a_pos_below_len, !o_stall && r_len != '0, r_pos < r_len, "position past end")
    `SASU_ASSERT_NEXT(a_accept_leaves_idle, w_in_acc, r_state != S_IDLE, "no start after accept")
    `SASU_ASSERT_NOW(a_result_src, $rose(r_out_valid), $past(r_state == S_RESULT), "stray result")

endmodule
